// ===== hw/rtl/wbit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Work/break interval timer package
// Request and result types, key codes, register indexes and timer constants
// shared by the interval timer.
// ----------------------------------------------------------------------------
package wbit_pkg;

	// Phase codes.
	localparam logic [1:0] PH_WORK  = 2'd0;
	localparam logic [1:0] PH_SHORT = 2'd1;
	localparam logic [1:0] PH_LONG  = 2'd2;

	// Request opcodes.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_KEY  = 1'b1;

	// Key codes (ASCII).
	localparam logic [7:0] KEY_PAUSE_LO = 8'h70;
	localparam logic [7:0] KEY_PAUSE_UP = 8'h50;
	localparam logic [7:0] KEY_QUIT_LO  = 8'h71;
	localparam logic [7:0] KEY_QUIT_UP  = 8'h51;
	localparam logic [7:0] KEY_SKIP_LO  = 8'h63;
	localparam logic [7:0] KEY_SKIP_UP  = 8'h43;

	// Configuration register indexes.
	localparam logic [1:0] REG_WORK_MINUTES        = 2'd0;
	localparam logic [1:0] REG_SHORT_BREAK_MINUTES = 2'd1;
	localparam logic [1:0] REG_LONG_BREAK_MINUTES  = 2'd2;

	// Register reset values.
	localparam logic [7:0] RST_WORK_MINUTES        = 8'd25;
	localparam logic [7:0] RST_SHORT_BREAK_MINUTES = 8'd5;
	localparam logic [7:0] RST_LONG_BREAK_MINUTES  = 8'd15;

	// Timer constants.
	localparam logic [3:0]  TICKS_PER_SECOND     = 4'd10;
	localparam int          WORKS_PER_LONG_BREAK = 4;
	localparam logic [23:0] WORK_SEC_MAX         = 24'hFF_FFFF;

	typedef struct packed {
		logic       opcode;
		logic [7:0] key_code;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [13:0] remaining_seconds;
		logic [2:0]  hour_ones;
		logic [2:0]  minute_tens;
		logic [3:0]  minute_ones;
		logic [2:0]  second_tens;
		logic [3:0]  second_ones;
		logic        is_paused;
		logic        is_stopped;
		logic        phase_started;
		logic [23:0] work_seconds_total;
		logic [15:0] completed_work_count;
	} out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/work_break_interval_timer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Work/break interval timer
// Counts work and break phases down from 100 ms ticks, reacts to pause, skip
// and quit keys, and reports the remaining time as binary and as digits.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  in       into       in_valid / in_stall   in_data  (opcode, key_code)
//  out      out of     out_valid / out_stall out_data (phase, time, flags)
//  cfg      into       cfg_wen               cfg_addr, cfg_wdata
//
// The block takes one request every clock cycle while the result register is
// not stalled, and gives one result for each. A request passes through an
// input register; the combinational update logic then writes the timer
// state and the result register together as the request leaves the input
// register. The remaining time is kept both in binary and as decimal digits,
// so no division is needed.
// Reset loads the register defaults (25, 5 and 15 minutes) and starts a
// 25-minute work phase. While the result register is stalled the input
// register still takes one request, after which in_stall is raised.
//
module work_break_interval_timer_top
	import wbit_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data,
	input  wire logic      cfg_wen,
	input  wire logic [1:0] cfg_addr,
	input  wire logic [7:0] cfg_wdata
);

	// Remaining time in binary and in digit form, updated side by side.
	typedef struct packed {
		logic [13:0] secs;
		logic [2:0]  hrs;
		logic [2:0]  min_t;
		logic [3:0]  min_o;
		logic [2:0]  sec_t;
		logic [3:0]  sec_o;
	} time_t;

	// Builds the starting time of a phase from its length in minutes. The
	// hours and the tens of minutes come from short compare chains.
	function automatic time_t load_time(input logic [7:0] minutes);
		time_t      t;
		logic [7:0] rem;
		logic [5:0] mins;
		logic [5:0] ones;
		t.secs = 14'(minutes) * 14'd60;
		if (minutes >= 8'd240) begin
			t.hrs = 3'd4;
		end else if (minutes >= 8'd180) begin
			t.hrs = 3'd3;
		end else if (minutes >= 8'd120) begin
			t.hrs = 3'd2;
		end else if (minutes >= 8'd60) begin
			t.hrs = 3'd1;
		end else begin
			t.hrs = 3'd0;
		end
		rem  = minutes - (8'(t.hrs) * 8'd60);
		mins = rem[5:0];
		if (mins >= 6'd50) begin
			t.min_t = 3'd5;
		end else if (mins >= 6'd40) begin
			t.min_t = 3'd4;
		end else if (mins >= 6'd30) begin
			t.min_t = 3'd3;
		end else if (mins >= 6'd20) begin
			t.min_t = 3'd2;
		end else if (mins >= 6'd10) begin
			t.min_t = 3'd1;
		end else begin
			t.min_t = 3'd0;
		end
		ones    = mins - (6'(t.min_t) * 6'd10);
		t.min_o = ones[3:0];
		t.sec_t = 3'd0;
		t.sec_o = 4'd0;
		return t;
	endfunction

	// Takes one second off a non-zero time, borrowing through the digits.
	function automatic time_t dec_time(input time_t t);
		time_t r;
		logic  b0;
		logic  b1;
		logic  b2;
		logic  b3;
		r       = t;
		r.secs  = t.secs - 14'd1;
		b0      = (t.sec_o == 4'd0);
		b1      = b0 && (t.sec_t == 3'd0);
		b2      = b1 && (t.min_o == 4'd0);
		b3      = b2 && (t.min_t == 3'd0);
		r.sec_o = b0 ? 4'd9 : t.sec_o - 4'd1;
		if (b0) begin
			r.sec_t = b1 ? 3'd5 : t.sec_t - 3'd1;
		end
		if (b1) begin
			r.min_o = b2 ? 4'd9 : t.min_o - 4'd1;
		end
		if (b2) begin
			r.min_t = b3 ? 3'd5 : t.min_t - 3'd1;
		end
		if (b3) begin
			r.hrs = t.hrs - 3'd1;
		end
		return r;
	endfunction

	// Configuration registers.
	logic [7:0] work_min_q;
	logic [7:0] short_min_q;
	logic [7:0] long_min_q;

	// Pipeline registers.
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;

	// Timer state.
	logic [1:0]  phase_q;
	time_t       time_q;
	logic [3:0]  tick_q;
	logic        pause_q;
	logic        stop_q;
	logic [15:0] wc_q;
	logic [23:0] ws_q;

	// Next-state values.
	logic [1:0]  phase_n;
	time_t       time_n;
	logic [3:0]  tick_n;
	logic [3:0]  tick_inc;
	logic        pause_n;
	logic        stop_n;
	logic [15:0] wc_n;
	logic [23:0] ws_n;
	logic        started;
	logic [7:0]  next_minutes;

	logic advance;
	logic fire;

	// The result register frees up when it is empty or being emptied.
	assign advance   = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_min_q  <= RST_WORK_MINUTES;
			short_min_q <= RST_SHORT_BREAK_MINUTES;
			long_min_q  <= RST_LONG_BREAK_MINUTES;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_WORK_MINUTES:        work_min_q  <= cfg_wdata;
				REG_SHORT_BREAK_MINUTES: short_min_q <= cfg_wdata;
				REG_LONG_BREAK_MINUTES:  long_min_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// One pass of the timer for the request held in the input register.
	always_comb begin
		phase_n      = phase_q;
		time_n       = time_q;
		tick_n       = tick_q;
		pause_n      = pause_q;
		stop_n       = stop_q;
		wc_n         = wc_q;
		ws_n         = ws_q;
		started      = 1'b0;
		next_minutes = work_min_q;
		tick_inc     = tick_q + 4'd1;
		if (!stop_q) begin
			if (item_s1.opcode == OP_KEY) begin
				if (item_s1.key_code inside {KEY_PAUSE_LO, KEY_PAUSE_UP}) begin
					pause_n = !pause_q;
				end else if (item_s1.key_code inside {KEY_QUIT_LO, KEY_QUIT_UP}) begin
					stop_n = 1'b1;
				end else if (item_s1.key_code inside {KEY_SKIP_LO, KEY_SKIP_UP}) begin
					time_n = '0;
				end
			end else if (!pause_q) begin
				tick_n = tick_inc;
				if (tick_inc >= TICKS_PER_SECOND) begin
					tick_n = 4'd0;
					if (phase_q == PH_WORK && ws_q != WORK_SEC_MAX) begin
						ws_n = ws_q + 24'd1;
					end
					if (time_q.secs == 14'd0) begin
						// The phase is over; the next one starts at once.
						started = 1'b1;
						pause_n = 1'b0;
						if (phase_q == PH_WORK) begin
							wc_n = wc_q + 16'd1;
							if ((wc_n % 16'(WORKS_PER_LONG_BREAK)) == 16'd0) begin
								phase_n = PH_LONG;
							end else begin
								phase_n = PH_SHORT;
							end
						end else begin
							phase_n = PH_WORK;
						end
						case (phase_n)
							PH_SHORT: next_minutes = short_min_q;
							PH_LONG:  next_minutes = long_min_q;
							default:  next_minutes = work_min_q;
						endcase
						time_n = load_time(next_minutes);
					end else begin
						time_n = dec_time(time_q);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_WORK;
			time_q      <= load_time(RST_WORK_MINUTES);
			tick_q      <= 4'd0;
			pause_q     <= 1'b0;
			stop_q      <= 1'b0;
			wc_q        <= 16'd0;
			ws_q        <= 24'd0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				phase_q <= phase_n;
				time_q  <= time_n;
				tick_q  <= tick_n;
				pause_q <= pause_n;
				stop_q  <= stop_n;
				wc_q    <= wc_n;
				ws_q    <= ws_n;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			out_q.phase                <= phase_n;
			out_q.remaining_seconds    <= time_n.secs;
			out_q.hour_ones            <= time_n.hrs;
			out_q.minute_tens          <= time_n.min_t;
			out_q.minute_ones          <= time_n.min_o;
			out_q.second_tens          <= time_n.sec_t;
			out_q.second_ones          <= time_n.sec_o;
			out_q.is_paused            <= pause_n;
			out_q.is_stopped           <= stop_n;
			out_q.phase_started        <= started;
			out_q.work_seconds_total   <= ws_n;
			out_q.completed_work_count <= wc_n;
		end
	end

`ifndef SYNTHESIS
	// The digits always spell out the binary remaining time.
	a_digits_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_data.hour_ones) * 32'd3600
			+ 32'(out_data.minute_tens) * 32'd600
			+ 32'(out_data.minute_ones) * 32'd60
			+ 32'(out_data.second_tens) * 32'd10
			+ 32'(out_data.second_ones)) == 32'(out_data.remaining_seconds))
		else $error("time digits disagree with remaining seconds");

	// Once stopped, the timer stays stopped and its time is frozen.
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |=> stop_q && $stable(time_q) && $stable(ws_q))
		else $error("stopped timer changed");

	// A new phase always starts unpaused and not stopped.
	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.phase_started |-> !out_data.is_paused
			&& !out_data.is_stopped)
		else $error("phase started while paused or stopped");

	// The input side only stalls while a request is held and blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// A stalled result is not overwritten by the update logic.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
